[design/cpu8_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_pkg: shared types and constants of the 8-bit execute unit
// Operation codes, status flag positions, register file and result types.
// ----------------------------------------------------------------------------
package cpu8_pkg;

	localparam int KIND_W = 6;

	// operation codes
	localparam logic [KIND_W-1:0] OP_LDA = 6'd0;
	localparam logic [KIND_W-1:0] OP_LDX = 6'd1;
	localparam logic [KIND_W-1:0] OP_LDY = 6'd2;
	localparam logic [KIND_W-1:0] OP_STA = 6'd3;
	localparam logic [KIND_W-1:0] OP_STX = 6'd4;
	localparam logic [KIND_W-1:0] OP_STY = 6'd5;
	localparam logic [KIND_W-1:0] OP_TAX = 6'd6;
	localparam logic [KIND_W-1:0] OP_TAY = 6'd7;
	localparam logic [KIND_W-1:0] OP_TXA = 6'd8;
	localparam logic [KIND_W-1:0] OP_TYA = 6'd9;
	localparam logic [KIND_W-1:0] OP_TSX = 6'd10;
	localparam logic [KIND_W-1:0] OP_TXS = 6'd11;
	localparam logic [KIND_W-1:0] OP_CLC = 6'd12;
	localparam logic [KIND_W-1:0] OP_CLD = 6'd13;
	localparam logic [KIND_W-1:0] OP_CLI = 6'd14;
	localparam logic [KIND_W-1:0] OP_CLV = 6'd15;
	localparam logic [KIND_W-1:0] OP_SEC = 6'd16;
	localparam logic [KIND_W-1:0] OP_SED = 6'd17;
	localparam logic [KIND_W-1:0] OP_SEI = 6'd18;
	localparam logic [KIND_W-1:0] OP_ADC = 6'd19;
	localparam logic [KIND_W-1:0] OP_SBC = 6'd20;
	localparam logic [KIND_W-1:0] OP_CMP = 6'd21;
	localparam logic [KIND_W-1:0] OP_CPX = 6'd22;
	localparam logic [KIND_W-1:0] OP_CPY = 6'd23;
	localparam logic [KIND_W-1:0] OP_AND = 6'd24;
	localparam logic [KIND_W-1:0] OP_ORA = 6'd25;
	localparam logic [KIND_W-1:0] OP_EOR = 6'd26;
	localparam logic [KIND_W-1:0] OP_BIT = 6'd27;
	localparam logic [KIND_W-1:0] OP_BPL = 6'd28;
	localparam logic [KIND_W-1:0] OP_BMI = 6'd29;
	localparam logic [KIND_W-1:0] OP_BVC = 6'd30;
	localparam logic [KIND_W-1:0] OP_BVS = 6'd31;
	localparam logic [KIND_W-1:0] OP_BCC = 6'd32;
	localparam logic [KIND_W-1:0] OP_BCS = 6'd33;
	localparam logic [KIND_W-1:0] OP_BNE = 6'd34;
	localparam logic [KIND_W-1:0] OP_BEQ = 6'd35;
	localparam logic [KIND_W-1:0] OP_PHA = 6'd36;
	localparam logic [KIND_W-1:0] OP_PHP = 6'd37;
	localparam logic [KIND_W-1:0] OP_PLA = 6'd38;
	localparam logic [KIND_W-1:0] OP_PLP = 6'd39;

	// status byte bit positions, NV-BDIZC
	localparam int FLAG_N = 7;
	localparam int FLAG_V = 6;
	localparam int FLAG_U = 5;
	localparam int FLAG_B = 4;
	localparam int FLAG_D = 3;
	localparam int FLAG_I = 2;
	localparam int FLAG_Z = 1;
	localparam int FLAG_C = 0;

	// stack access codes
	localparam logic [1:0] SA_NONE = 2'd0;
	localparam logic [1:0] SA_PUSH = 2'd1;
	localparam logic [1:0] SA_PULL = 2'd2;

	localparam logic [7:0] SP_RESET = 8'hFF;
	localparam logic       PAGE1_MSB = 1'b1;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} arch_t;

	localparam arch_t ARCH_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: 8'h00};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        operand_byte;
		logic [15:0]       next_pc;
	} item_t;

	typedef struct packed {
		logic        write_enable;
		logic [7:0]  write_data;
		logic [1:0]  stack_access;
		logic [8:0]  stack_address;
		logic [15:0] pc_out;
	} res_t;

	// update N and Z from a result byte
	function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] v);
		logic [7:0] f;
		f = flags;
		f[FLAG_N] = v[7];
		f[FLAG_Z] = (v == 8'h00);
		return f;
	endfunction

endpackage
`default_nettype wire

[design/cpu8_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_alu: single-pass execute logic
// Next register file and result fields for one operation.
// ----------------------------------------------------------------------------
module cpu8_alu (
	input  cpu8_pkg::arch_t cur,
	input  cpu8_pkg::item_t item,
	output cpu8_pkg::arch_t nxt,
	output cpu8_pkg::res_t  res
);

	logic [7:0]  m;
	logic [7:0]  add_op;
	logic [8:0]  sum9;
	logic [7:0]  cmp_reg;
	logic [8:0]  diff9;
	logic        taken;
	logic [7:0]  sp_dec;
	logic [7:0]  sp_inc;

	assign m      = item.operand_byte;
	assign add_op = (item.kind == cpu8_pkg::OP_SBC) ? ~m : m;
	assign sum9   = {1'b0, cur.a} + {1'b0, add_op} + {8'b0, cur.p[cpu8_pkg::FLAG_C]};
	assign sp_dec = cur.sp - 8'd1;
	assign sp_inc = cur.sp + 8'd1;

	always_comb begin
		case (item.kind)
			cpu8_pkg::OP_CPX: cmp_reg = cur.x;
			cpu8_pkg::OP_CPY: cmp_reg = cur.y;
			default:          cmp_reg = cur.a;
		endcase
	end

	assign diff9 = {1'b0, cmp_reg} - {1'b0, m};

	always_comb begin
		nxt                = cur;
		res.write_enable   = 1'b0;
		res.write_data     = 8'h00;
		res.stack_access   = cpu8_pkg::SA_NONE;
		res.stack_address  = {cpu8_pkg::PAGE1_MSB, cur.sp};
		taken              = 1'b0;
		unique case (item.kind) inside
			cpu8_pkg::OP_LDA: begin
				nxt.a = m;
				nxt.p = cpu8_pkg::set_nz(cur.p, m);
			end
			cpu8_pkg::OP_LDX: begin
				nxt.x = m;
				nxt.p = cpu8_pkg::set_nz(cur.p, m);
			end
			cpu8_pkg::OP_LDY: begin
				nxt.y = m;
				nxt.p = cpu8_pkg::set_nz(cur.p, m);
			end
			cpu8_pkg::OP_STA: begin
				res.write_enable = 1'b1;
				res.write_data   = cur.a;
			end
			cpu8_pkg::OP_STX: begin
				res.write_enable = 1'b1;
				res.write_data   = cur.x;
			end
			cpu8_pkg::OP_STY: begin
				res.write_enable = 1'b1;
				res.write_data   = cur.y;
			end
			cpu8_pkg::OP_TAX: begin
				nxt.x = cur.a;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.a);
			end
			cpu8_pkg::OP_TAY: begin
				nxt.y = cur.a;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.a);
			end
			cpu8_pkg::OP_TXA: begin
				nxt.a = cur.x;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.x);
			end
			cpu8_pkg::OP_TYA: begin
				nxt.a = cur.y;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.y);
			end
			cpu8_pkg::OP_TSX: begin
				nxt.x = cur.sp;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.sp);
			end
			cpu8_pkg::OP_TXS: nxt.sp = cur.x;
			cpu8_pkg::OP_CLC: nxt.p[cpu8_pkg::FLAG_C] = 1'b0;
			cpu8_pkg::OP_CLD: nxt.p[cpu8_pkg::FLAG_D] = 1'b0;
			cpu8_pkg::OP_CLI: nxt.p[cpu8_pkg::FLAG_I] = 1'b0;
			cpu8_pkg::OP_CLV: nxt.p[cpu8_pkg::FLAG_V] = 1'b0;
			cpu8_pkg::OP_SEC: nxt.p[cpu8_pkg::FLAG_C] = 1'b1;
			cpu8_pkg::OP_SED: nxt.p[cpu8_pkg::FLAG_D] = 1'b1;
			cpu8_pkg::OP_SEI: nxt.p[cpu8_pkg::FLAG_I] = 1'b1;
			cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC: begin
				nxt.a = sum9[7:0];
				nxt.p = cpu8_pkg::set_nz(cur.p, sum9[7:0]);
				nxt.p[cpu8_pkg::FLAG_C] = sum9[8];
				nxt.p[cpu8_pkg::FLAG_V] = ~(cur.a[7] ^ add_op[7]) & (cur.a[7] ^ sum9[7]);
			end
			cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY: begin
				nxt.p[cpu8_pkg::FLAG_C] = ~diff9[8];
				nxt.p[cpu8_pkg::FLAG_Z] = (cmp_reg == m);
				nxt.p[cpu8_pkg::FLAG_N] = diff9[7];
			end
			cpu8_pkg::OP_AND: begin
				nxt.a = cur.a & m;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.a & m);
			end
			cpu8_pkg::OP_ORA: begin
				nxt.a = cur.a | m;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.a | m);
			end
			cpu8_pkg::OP_EOR: begin
				nxt.a = cur.a ^ m;
				nxt.p = cpu8_pkg::set_nz(cur.p, cur.a ^ m);
			end
			cpu8_pkg::OP_BIT: begin
				nxt.p[cpu8_pkg::FLAG_Z] = ((cur.a & m) == 8'h00);
				nxt.p[cpu8_pkg::FLAG_N] = m[7];
				nxt.p[cpu8_pkg::FLAG_V] = m[6];
			end
			cpu8_pkg::OP_BPL: taken = ~cur.p[cpu8_pkg::FLAG_N];
			cpu8_pkg::OP_BMI: taken =  cur.p[cpu8_pkg::FLAG_N];
			cpu8_pkg::OP_BVC: taken = ~cur.p[cpu8_pkg::FLAG_V];
			cpu8_pkg::OP_BVS: taken =  cur.p[cpu8_pkg::FLAG_V];
			cpu8_pkg::OP_BCC: taken = ~cur.p[cpu8_pkg::FLAG_C];
			cpu8_pkg::OP_BCS: taken =  cur.p[cpu8_pkg::FLAG_C];
			cpu8_pkg::OP_BNE: taken = ~cur.p[cpu8_pkg::FLAG_Z];
			cpu8_pkg::OP_BEQ: taken =  cur.p[cpu8_pkg::FLAG_Z];
			cpu8_pkg::OP_PHA, cpu8_pkg::OP_PHP: begin
				res.write_enable  = 1'b1;
				res.write_data    = (item.kind == cpu8_pkg::OP_PHA) ? cur.a
				                    : (cur.p | 8'h30);
				res.stack_access  = cpu8_pkg::SA_PUSH;
				res.stack_address = {cpu8_pkg::PAGE1_MSB, cur.sp};
				nxt.sp            = sp_dec;
			end
			cpu8_pkg::OP_PLA: begin
				res.stack_access  = cpu8_pkg::SA_PULL;
				res.stack_address = {cpu8_pkg::PAGE1_MSB, sp_inc};
				nxt.sp            = sp_inc;
				nxt.a             = m;
				nxt.p             = cpu8_pkg::set_nz(cur.p, m);
			end
			cpu8_pkg::OP_PLP: begin
				res.stack_access  = cpu8_pkg::SA_PULL;
				res.stack_address = {cpu8_pkg::PAGE1_MSB, sp_inc};
				nxt.sp            = sp_inc;
				// drop B and the unused bit
				nxt.p             = m & 8'hCF;
			end
			default: ;
		endcase
		// without stack access the address tracks the final stack pointer
		if (res.stack_access == cpu8_pkg::SA_NONE) begin
			res.stack_address = {cpu8_pkg::PAGE1_MSB, nxt.sp};
		end
		res.pc_out = taken ? (item.next_pc + {{8{m[7]}}, m}) : item.next_pc;
	end

endmodule
`default_nettype wire

[design/cpu8_instruction_execute_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// An item passes the input register (stage 1), then the output register (stage 2), before its result is valid.
// One operation per clock unless m_tready stalls; register file updates as the item leaves stage 1.
// The output register frees and reloads in the same cycle, so no bubble under continuous flow.
// Reset (arst_n low, asynchronous): valids cleared, A/X/Y/P = 0, SP = 0xFF.
// ----------------------------------------------------------------------------
// cpu8_instruction_execute_unit: 8-bit CPU execute stage
// Runs loads, stores, transfers, flag ops, binary ADC/SBC, compares, logic,
// BIT, branches and stack push/pull against the A, X, Y, SP and P registers.
// ----------------------------------------------------------------------------
module cpu8_instruction_execute_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // operand_byte[7:0], next_pc[23:8]
	input  wire logic [5:0]  s_tuser,  // kind[5:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// write_data[7:0], stack_address[16:8], acc_out[24:17], x_out[32:25],
	// y_out[40:33], sp_out[48:41], flags_out[56:49], pc_out[72:57], zero fill [79:73]
	output logic [79:0]      m_tdata,
	output logic [2:0]       m_tuser   // write_enable[0], stack_access[2:1]
);

	// stage 1: registered input item
	logic              valid_s1;
	cpu8_pkg::item_t   item_s1;

	// architectural registers
	cpu8_pkg::arch_t   arch_q;

	// stage 2: output register
	logic              valid_s2;
	cpu8_pkg::arch_t   arch_s2;
	cpu8_pkg::res_t    res_s2;

	cpu8_pkg::arch_t   arch_nxt;
	cpu8_pkg::res_t    res_nxt;

	logic              in_fire;
	logic              advance;

	// advance stage 1 into the output register whenever that register is empty or drains
	assign advance  = ~valid_s2 | m_tready;
	assign s_tready = ~valid_s1 | advance;
	assign in_fire  = s_tvalid & s_tready;

	cpu8_alu u_alu (
		.cur  (arch_q),
		.item (item_s1),
		.nxt  (arch_nxt),
		.res  (res_nxt)
	);

	// control state and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			arch_q   <= cpu8_pkg::ARCH_RESET;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			// commit the register file as the item leaves stage 1
			if (advance && valid_s1) begin
				arch_q <= arch_nxt;
			end
		end
	end

	// payload: hold while stalled, load on transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.kind         <= s_tuser;
			item_s1.operand_byte <= s_tdata[7:0];
			item_s1.next_pc      <= s_tdata[23:8];
		end
		if (advance && valid_s1) begin
			arch_s2 <= arch_nxt;
			res_s2  <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, res_s2.pc_out, arch_s2.p, arch_s2.sp, arch_s2.y, arch_s2.x,
	                   arch_s2.a, res_s2.stack_address, res_s2.write_data};
	assign m_tuser  = {res_s2.stack_access, res_s2.write_enable};

endmodule
`default_nettype wire

[design/cpu8_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_checker: port-level assertions for the execute unit
// Watches the result stream for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module cpu8_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// write data reads zero without a write
	a_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
		else $error("write_data nonzero without write_enable");

	// push always writes, pull never writes
	a_stack_we: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2:1] != cpu8_pkg::SA_PUSH || m_tuser[0])
			&& (m_tuser[2:1] != cpu8_pkg::SA_PULL || !m_tuser[0]))
		else $error("stack access and write_enable disagree");

	// stack address stays in page one, flag bits B and 5 never held
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16] && m_tdata[54:53] == 2'b00)
		else $error("stack address or status byte malformed");

	// without stack access the address equals page one plus the new stack pointer
	a_saddr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == cpu8_pkg::SA_NONE |-> m_tdata[15:8] == m_tdata[48:41])
		else $error("idle stack address does not track sp_out");

endmodule

bind cpu8_instruction_execute_unit cpu8_checker u_cpu8_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
